>>> rtl/core/f2h_pkg.sv
package f2h_pkg;

   // Biased single-precision exponent thresholds (half exponent e = exp - 112)
   localparam logic [7:0] EXP_REBIAS     = 8'd112;  // 127 - 15
   localparam logic [7:0] EXP_ZERO_BELOW = 8'd102;  // e < -10 flushes to zero
   localparam logic [7:0] EXP_SUB_MAX    = 8'd112;  // e <= 0 is subnormal
   localparam logic [7:0] EXP_INF_MIN    = 8'd143;  // e >= 31 saturates
   localparam logic [7:0] EXP_SHIFT_BASE = 8'd113;  // shift = 1 - e
   localparam logic [14:0] HALF_INF      = 15'h7C00;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_SUB,
      CLS_NORM,
      CLS_INF
   } cls_type;

   // Beat after decode
   typedef struct packed {
      logic        sign;
      cls_type     cls;
      logic [3:0]  shift;
      logic [4:0]  exp;
      logic [22:0] frac;
   } dec_type;

   // Beat after alignment: sig holds single bits 22..12 (bit 0 is the round bit)
   typedef struct packed {
      logic        sign;
      cls_type     cls;
      logic [4:0]  exp;
      logic [10:0] sig;
   } aln_type;

endpackage

>>> rtl/core/float32_to_half_convert.sv
// Single- to half-precision converter. One binary32 pattern is taken per
// cycle on start (busy never rises) and its binary16 pattern appears on
// rsp_half_bits, marked by a one-cycle rsp_valid strobe, after passing
// through three register stages: exponent decode, subnormal alignment
// shift, and round with exponent carry. The receiver cannot stall the
// block, so results must be captured when strobed. Rounding is half
// away from zero, values below the subnormal range flush to signed zero,
// and overflow, infinity and NaN all give signed infinity.
module float32_to_half_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_single_bits,
   output logic        rsp_valid,
   output logic [15:0] rsp_half_bits
);
   import f2h_pkg::*;

   logic    dec_valid;
   dec_type dec_beat;
   logic    aln_valid;
   aln_type aln_beat;
   logic    accept_w;

   // Pipeline takes a beat every cycle
   assign busy     = 1'b0;
   assign accept_w = start & ~busy;

   f2h_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept_w),
      .in_bits   (req_single_bits),
      .out_valid (dec_valid),
      .out_beat  (dec_beat)
   );

   f2h_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_beat   (dec_beat),
      .out_valid (aln_valid),
      .out_beat  (aln_beat)
   );

   f2h_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (aln_valid),
      .in_beat   (aln_beat),
      .out_valid (rsp_valid),
      .out_bits  (rsp_half_bits)
   );

endmodule

>>> rtl/core/f2h_decode.sv
module f2h_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [31:0]      in_bits,
   output logic             out_valid,
   output f2h_pkg::dec_type out_beat
);
   import f2h_pkg::*;

   logic       valid_ff, valid_in;
   dec_type    beat_ff, beat_in;
   logic [7:0] exp_w;
   logic [7:0] rebias_w;
   logic [7:0] shift_w;

   // Classify the exponent and work out the subnormal shift
   always_comb begin
      exp_w    = in_bits[30:23];
      rebias_w = exp_w - EXP_REBIAS;
      shift_w  = EXP_SHIFT_BASE - exp_w;
      valid_in = in_valid;
      beat_in.sign  = in_bits[31];
      beat_in.frac  = in_bits[22:0];
      beat_in.exp   = rebias_w[4:0];
      beat_in.shift = shift_w[3:0];
      priority if (exp_w < EXP_ZERO_BELOW) begin
         beat_in.cls = CLS_ZERO;
      end else if (exp_w <= EXP_SUB_MAX) begin
         beat_in.cls = CLS_SUB;
      end else if (exp_w >= EXP_INF_MIN) begin
         beat_in.cls = CLS_INF;
      end else begin
         beat_in.cls = CLS_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

>>> rtl/core/f2h_align.sv
module f2h_align (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  f2h_pkg::dec_type in_beat,
   output logic             out_valid,
   output f2h_pkg::aln_type out_beat
);
   import f2h_pkg::*;

   logic        valid_ff, valid_in;
   aln_type     beat_ff, beat_in;
   logic [23:0] shifted_w;

   // Restore the hidden bit and denormalise for the subnormal range
   always_comb begin
      shifted_w    = {1'b1, in_beat.frac} >> in_beat.shift;
      valid_in     = in_valid;
      beat_in.sign = in_beat.sign;
      beat_in.cls  = in_beat.cls;
      if (in_beat.cls == CLS_SUB) begin
         beat_in.exp = 5'd0;
         beat_in.sig = shifted_w[22:12];
      end else begin
         beat_in.exp = in_beat.exp;
         beat_in.sig = in_beat.frac[22:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

>>> rtl/core/f2h_round.sv
module f2h_round (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  f2h_pkg::aln_type in_beat,
   output logic             out_valid,
   output logic [15:0]      out_bits
);
   import f2h_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] bits_ff, bits_in;
   logic [14:0] mag_w;

   // Round half away from zero; a mantissa carry ripples into the exponent,
   // and a carry to exponent 31 lands exactly on infinity
   always_comb begin
      mag_w    = {in_beat.exp, in_beat.sig[10:1]} + {14'd0, in_beat.sig[0]};
      valid_in = in_valid;
      unique case (in_beat.cls)
         CLS_ZERO: bits_in = {in_beat.sign, 15'd0};
         CLS_INF:  bits_in = {in_beat.sign, HALF_INF};
         default:  bits_in = {in_beat.sign, mag_w};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bits_ff <= bits_in;
   end

   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;

endmodule

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STALL_LIMIT = 1000;  // cycles with no beat on either side
   localparam int          DRAIN_WAIT  = 8;     // pipeline is three stages deep
   localparam int          HALF_BIAS_D = 112;   // 127 - 15
   localparam int          EXP_TOP     = 31;
   localparam int          SUB_FLOOR   = -10;
   localparam logic [14:0] INF_BITS    = 15'h7C00;
   localparam logic [23:0] RND_BIT     = 24'h001000;
   localparam logic [23:0] ULP_ADD     = 24'h002000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_single_bits = '0;
   logic        busy;
   logic        rsp_valid;
   logic [15:0] rsp_half_bits;

   logic [15:0] half_pending[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          gaps_on = 1'b0;

   float32_to_half_convert i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_single_bits (req_single_bits),
      .rsp_valid       (rsp_valid),
      .rsp_half_bits   (rsp_half_bits)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Expected half pattern for one single pattern; ties round away from zero
   function automatic logic [15:0] single_to_half(input logic [31:0] w);
      logic        sgn;
      int          e;
      logic [23:0] sig;
      sgn = w[31];
      e   = int'(w[30:23]) - HALF_BIAS_D;
      if (e <= 0) begin
         if (e < SUB_FLOOR) return {sgn, 15'd0};
         sig = {1'b1, w[22:0]} >> (1 - e);
         if ((sig & RND_BIT) != 0) sig = sig + ULP_ADD;
         return {sgn, 4'd0, sig[23:13]};
      end
      if (e >= EXP_TOP) return {sgn, INF_BITS};
      sig = {1'b0, w[22:0]};
      if ((sig & RND_BIT) != 0) begin
         sig = sig + ULP_ADD;
         if (sig[23]) begin
            sig = '0;
            e   = e + 1;
            if (e >= EXP_TOP) return {sgn, INF_BITS};
         end
      end
      return {sgn, e[4:0], sig[22:13]};
   endfunction

   // Beat monitor: queue the prediction on each accepted input, check each strobed
   // result against the oldest prediction, and watch for a stuck run
   always @(posedge clock) begin
      logic [15:0] want;
      bit          moved;
      moved = 1'b0;
      if (!reset && start && busy === 1'b0) begin
         half_pending.push_back(single_to_half(req_single_bits));
         moved = 1'b1;
      end
      if (!reset && rsp_valid === 1'b1) begin
         moved = 1'b1;
         if (half_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: half_bits=%h", rsp_half_bits);
         end else begin
            want = half_pending.pop_front();
            if (rsp_half_bits !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("half_bits mismatch: expected %h, got %h", want, rsp_half_bits);
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Drive one beat and hold it until taken; start stays high for the next beat unless a random gap is inserted
   task automatic send_single(input logic [31:0] w);
      start           <= 1'b1;
      req_single_bits <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start           <= 1'b0;
         req_single_bits <= $urandom();
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Sender stops until every outstanding result has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (half_pending.size() != 0) @(posedge clock);
   endtask

   // Field extremes, rounding ties, range boundaries and special values
   task automatic test_directed();
      logic [31:0] pats[$];
      pats = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
               32'h32FF_FFFF, 32'h3300_0000, 32'hB300_0000, 32'h3380_0000,
               32'h387F_F000, 32'h387F_EFFF, 32'h3880_0000, 32'h3F80_0000,
               32'h3F80_1000, 32'hBF80_0FFF, 32'h3FFF_F000, 32'h477F_E000,
               32'h477F_EFFF, 32'h477F_F000, 32'h4780_0000, 32'h7F80_0000,
               32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF};
      foreach (pats[k]) send_single(pats[k]);
   endtask

   // Random patterns, weighted towards the exponents the half format can reach
   task automatic test_random(input int count);
      logic [31:0] w;
      for (int n = 0; n < count; n++) begin
         w = $urandom();
         case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6: w[30:23] = 8'($urandom_range(98, 146));
            7: w[30:23] = 8'($urandom_range(100, 113));
            default: begin
               // near a rounding tie
               w[30:23] = 8'($urandom_range(100, 144));
               w[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
            end
         endcase
         send_single(w);
      end
   endtask

   // Back-to-back beats with no sender gaps
   task automatic test_streaming(input int count);
      gaps_on = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 2 == 0) send_single($urandom());
         else send_single({$urandom_range(0, 1) == 1, 8'($urandom_range(100, 145)),
                           23'($urandom())});
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_drained();
      gaps_on = 1'b1;
      test_random(340);
      wait_drained();
      gaps_on = 1'b1;
      test_random(340);
      test_streaming(60);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (half_pending.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/f2h_pkg.sv
rtl/core/f2h_decode.sv
rtl/core/f2h_align.sv
rtl/core/f2h_round.sv
rtl/core/float32_to_half_convert.sv
verif/tb.sv
